FILE: sv/sbx_pkg.sv
// Shared types, constants and GF(2^8) helper functions for the S-box block.
package sbx_pkg;

   localparam logic [8:0] FIELD_POLY = 9'h11B;
   localparam logic [7:0] FWD_CONST  = 8'h63;
   localparam logic [7:0] INV_CONST  = 8'h05;

   // square-and-multiply rounds that build a^127
   localparam int unsigned ROUNDS = 6;
   localparam int unsigned RND_W  = $clog2(ROUNDS);
   localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_MULTIPLY,
      ST_LAST
   } state_type;

   typedef struct packed {
      logic load;
      logic square;
      logic multiply;
      logic finish;
   } cmd_type;

   function automatic logic [7:0] rotl(input logic [7:0] v, input int unsigned k);
      logic [15:0] w;
      w = {v, v} << (k % 8);
      return w[15:8];
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [8:0] x;
      acc = 8'h00;
      x   = {1'b0, a};
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ x[7:0];
         x = {x[7:0], 1'b0};
         if (x[8]) x = x ^ FIELD_POLY;
      end
      return acc;
   endfunction

   function automatic logic [7:0] affine_fwd(input logic [7:0] a);
      return a ^ rotl(a, 1) ^ rotl(a, 2) ^ rotl(a, 3) ^ rotl(a, 4) ^ FWD_CONST;
   endfunction

   function automatic logic [7:0] affine_inv(input logic [7:0] a);
      return rotl(a, 1) ^ rotl(a, 3) ^ rotl(a, 6) ^ INV_CONST;
   endfunction

endpackage

FILE: sv/sbx_dpath.sv
// Datapath: operand registers, shared GF(2^8) multiplier and result register.
module sbx_dpath import sbx_pkg::*; (
   input  logic       clock,
   input  cmd_type    cmd,
   input  logic       op,
   input  logic [7:0] data_in,
   output logic [7:0] data_out
);

   logic       op_ff,   op_in;
   logic [7:0] base_ff, base_in;
   logic [7:0] acc_ff,  acc_in;
   logic [7:0] out_ff,  out_in;
   logic [7:0] mul_b;
   logic [7:0] prod;

   assign mul_b = cmd.multiply ? base_ff : acc_ff;
   assign prod  = gf_mul(acc_ff, mul_b);

   always_comb begin
      op_in   = op_ff;
      base_in = base_ff;
      acc_in  = acc_ff;
      out_in  = out_ff;
      if (cmd.load) begin
         op_in   = op;
         base_in = op ? affine_inv(data_in) : data_in;
         acc_in  = base_in;
      end
      if (cmd.square || cmd.multiply) acc_in = prod;
      if (cmd.finish) out_in = op_ff ? prod : affine_fwd(prod);
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
   end

   assign data_out = out_ff;

endmodule

FILE: sv/sbx_ctrl.sv
// Controller: sequences the square/multiply rounds and raises the result strobe.
module sbx_ctrl import sbx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    done,
   output cmd_type cmd
);

   state_type        state_ff, state_in;
   logic [RND_W-1:0] rnd_ff,   rnd_in;
   logic             done_ff,  done_in;

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rnd_in = '0;
            if (start) state_in = ST_SQUARE;
         end
         ST_SQUARE: state_in = ST_MULTIPLY;
         ST_MULTIPLY: begin
            if (rnd_ff == RND_LAST) begin
               state_in = ST_LAST;
            end else begin
               rnd_in   = rnd_ff + 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_LAST: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd     = '0;
      busy    = 1'b1;
      done_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SQUARE:   cmd.square   = 1'b1;
         ST_MULTIPLY: cmd.multiply = 1'b1;
         ST_LAST: begin
            cmd.finish = 1'b1;
            done_in    = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         done_ff  <= done_in;
      end
   end

   assign done = done_ff;

endmodule

FILE: sv/aes_sbox_gf_inverse.sv
// Top level: AES S-box / inverse S-box by GF(2^8) inversion (a^254).
// One word at a time: its 13 passes go through one GF multiplier, so no new word is taken while busy.
// busy is low again in the cycle the result is strobed, so a new word may start then.
// Synchronous active-high reset clears the controller; no result is pending after reset.
// The receiver cannot stall; each result is valid for exactly one cycle.
module aes_sbox_gf_inverse import sbx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_op,
   input  logic [7:0] req_data_in,
   output logic       rsp_valid,
   output logic [7:0] rsp_data_out
);

   cmd_type cmd;

   sbx_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .done  (rsp_valid),
      .cmd   (cmd)
   );

   sbx_dpath u_dpath (
      .clock    (clock),
      .cmd      (cmd),
      .op       (req_op),
      .data_in  (req_data_in),
      .data_out (rsp_data_out)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##14 rsp_valid)
      else $error("result strobe missing");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobed twice");

   a_idle_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("strobe while busy");

endmodule

FILE: dv/aes_sbox_gf_inverse_checker.sv
`timescale 1ns / 1ps
// Checker for the S-box block: predicts each substituted byte and compares it on the strobe.
module aes_sbox_gf_inverse_checker import sbx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic       req_op,
   input  logic [7:0] req_data_in,
   input  logic       rsp_valid,
   input  logic [7:0] rsp_data_out,
   output int         fail_count,
   output int         outstanding
);

   typedef struct packed {
      logic       op;
      logic [7:0] din;
      logic [7:0] sub;
   } sub_word_type;

   sub_word_type pending_subs[$];

   // shift-and-add product, reducing by the field polynomial on each carry
   function automatic logic [7:0] field_product(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 7; i >= 0; i--) begin
         p = p[7] ? ({p[6:0], 1'b0} ^ FIELD_POLY[7:0]) : {p[6:0], 1'b0};
         if (b[i]) p = p ^ a;
      end
      return p;
   endfunction

   // a^254; zero maps to zero
   function automatic logic [7:0] field_recip(input logic [7:0] a);
      logic [7:0] r;
      r = 8'h01;
      for (int i = 0; i < 254; i++) r = field_product(r, a);
      return r;
   endfunction

   function automatic logic [7:0] mix_fwd(input logic [7:0] a);
      logic [7:0] b;
      for (int i = 0; i < 8; i++)
         b[i] = a[i] ^ a[(i + 4) % 8] ^ a[(i + 5) % 8] ^ a[(i + 6) % 8] ^ a[(i + 7) % 8];
      return b ^ FWD_CONST;
   endfunction

   function automatic logic [7:0] mix_inv(input logic [7:0] a);
      logic [7:0] b;
      for (int i = 0; i < 8; i++)
         b[i] = a[(i + 7) % 8] ^ a[(i + 5) % 8] ^ a[(i + 2) % 8];
      return b ^ INV_CONST;
   endfunction

   function automatic logic [7:0] substitute(input logic op, input logic [7:0] d);
      if (!op) return mix_fwd(field_recip(d));
      return field_recip(mix_inv(d));
   endfunction

   always @(posedge clock) begin
      sub_word_type w;
      int           fails;
      fails = fail_count;
      if (reset) begin
         pending_subs.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_subs.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %02h",
                        $time, rsp_data_out);
               fails++;
            end else begin
               w = pending_subs.pop_front();
               if (rsp_data_out !== w.sub) begin
                  $display("%0t: data_out mismatch (op %0d, in %02h): expected %02h actual %02h",
                           $time, w.op, w.din, w.sub, rsp_data_out);
                  fails++;
               end
            end
         end
         if (start && !busy) begin
            w.op  = req_op;
            w.din = req_data_in;
            w.sub = substitute(req_op, req_data_in);
            pending_subs.push_back(w);
         end
      end
      fail_count  <= fails;
      outstanding <= pending_subs.size();
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Top of the S-box testbench: clock, reset, directed and random words, and the verdict.
module tb;
   import sbx_pkg::*;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic       req_op;
   logic [7:0] req_data_in;
   logic       rsp_valid;
   logic [7:0] rsp_data_out;
   int         fail_count;
   int         outstanding;

   aes_sbox_gf_inverse dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_data_in  (req_data_in),
      .rsp_valid    (rsp_valid),
      .rsp_data_out (rsp_data_out)
   );

   aes_sbox_gf_inverse_checker chk (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_data_in  (req_data_in),
      .rsp_valid    (rsp_valid),
      .rsp_data_out (rsp_data_out),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // holds start high until the word is taken; start stays high on return
   task automatic send_word(input logic op, input logic [7:0] d, input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start       <= 1'b0;
         req_op      <= 1'($urandom);
         req_data_in <= 8'($urandom);
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
      start       <= 1'b1;
      req_op      <= op;
      req_data_in <= d;
      do @(posedge clock); while (busy);
   endtask

   logic [8:0] directed_words[] = '{
      {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h01}, {1'b0, 8'h80}, {1'b0, 8'h02},
      {1'b0, 8'h55}, {1'b0, 8'hAA}, {1'b0, 8'h63}, {1'b0, 8'h7F}, {1'b0, 8'h53},
      {1'b1, 8'h63}, {1'b1, 8'h00}, {1'b1, 8'hFF}, {1'b1, 8'h01}, {1'b1, 8'h80},
      {1'b1, 8'h7C}, {1'b1, 8'h16}, {1'b1, 8'h52}, {1'b1, 8'hAA}, {1'b1, 8'h55}
   };
   int idle_by_phase[4] = '{0, 71, 0, 6};

   initial begin
      logic [7:0] d;
      int         waited;
      reset       = 1'b1;
      start       = 1'b0;
      req_op      = 1'b0;
      req_data_in = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_words[i])
         send_word(directed_words[i][8], directed_words[i][7:0], 0);

      foreach (idle_by_phase[p]) begin
         for (int n = 0; n < 175; n++) begin
            case ($urandom_range(9))
               0:       d = 8'h00;
               1:       d = 8'h63;
               2:       d = 8'hFF;
               default: d = 8'($urandom);
            endcase
            send_word(1'($urandom), d, idle_by_phase[p]);
         end
      end
      start <= 1'b0;

      waited = 0;
      while (outstanding != 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      repeat (30) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/sbx_pkg.sv
sv/sbx_dpath.sv
sv/sbx_ctrl.sv
sv/aes_sbox_gf_inverse.sv
dv/aes_sbox_gf_inverse_checker.sv
dv/tb.sv
